// File: rtl/core/rct_pkg.sv
package rct_pkg;

    localparam int C_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        FLT_OK    = 2'd0,
        FLT_SUM   = 2'd1,
        FLT_DEN   = 2'd2,
        FLT_CLAMP = 2'd3
    } t_fault;

    typedef struct packed {
        logic        zs;
        logic        zd;
        logic        sat;
        logic        luxc;
        logic [15:0] lux;
    } t_side;

endpackage

// File: rtl/core/rct_xyz.sv
module rct_xyz
    import rct_pkg::*;
#(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [15:0]            i_red,
    input  logic [15:0]            i_green,
    input  logic [15:0]            i_blue,
    output logic                   o_valid,
    output logic [FRAC_BITS+32:0]  o_un,
    output logic [FRAC_BITS+32:0]  o_ud,
    output logic                   o_neg,
    output t_side                  o_side
);

    localparam int     CW = FRAC_BITS + 3;
    localparam int     PW = FRAC_BITS + 20;
    localparam int     XW = FRAC_BITS + 21;
    localparam int     NW = FRAC_BITS + 34;
    localparam int     MW = FRAC_BITS + 33;
    localparam longint LF = 64'sd1 <<< FRAC_BITS;

    localparam logic signed [CW-1:0] K_XR = CW'(-((14282 * LF + 50000) / 100000));
    localparam logic signed [CW-1:0] K_XG = CW'((154924 * LF + 50000) / 100000);
    localparam logic signed [CW-1:0] K_XB = CW'(-((95641 * LF + 50000) / 100000));
    localparam logic signed [CW-1:0] K_YR = CW'(-((32466 * LF + 50000) / 100000));
    localparam logic signed [CW-1:0] K_YG = CW'((157837 * LF + 50000) / 100000);
    localparam logic signed [CW-1:0] K_YB = CW'(-((73191 * LF + 50000) / 100000));
    localparam logic signed [CW-1:0] K_ZR = CW'(-((68202 * LF + 50000) / 100000));
    localparam logic signed [CW-1:0] K_ZG = CW'((77073 * LF + 50000) / 100000);
    localparam logic signed [CW-1:0] K_ZB = CW'((56332 * LF + 50000) / 100000);

    localparam logic signed [NW-1:0] M_10K  = NW'(10000);
    localparam logic signed [NW-1:0] M_3320 = NW'(3320);
    localparam logic signed [NW-1:0] M_1858 = NW'(1858);
    localparam logic signed [XW-1:0] Y_LIM  = XW'(-LF);
    localparam logic signed [XW-1:0] U_MAX  = XW'(65535);

    logic [5:0]             r_v;
    logic signed [PW-1:0]   r_p [9];
    logic signed [XW-1:0]   r_x, r_y, r_z;
    logic signed [XW-1:0]   r_s, r_x3, r_y3;
    logic signed [NW-1:0]   r_xa, r_sa, r_sb, r_yb;
    logic signed [NW-1:0]   r_num, r_den;
    logic [MW-1:0]          r_un, r_ud;
    logic                   r_neg;
    t_side                  r_sd3, r_sd4, r_sd5, r_sd6;
    t_side                  n_sd3, n_sd4, n_sd5;

    logic signed [16:0]     w_r, w_g, w_b;
    logic signed [XW-1:0]   w_yq;

    assign w_r  = $signed({1'b0, i_red});
    assign w_g  = $signed({1'b0, i_green});
    assign w_b  = $signed({1'b0, i_blue});
    assign w_yq = r_y >>> FRAC_BITS;

    always_comb begin
        n_sd3     = '0;
        if (r_y[XW-1]) begin
            n_sd3.luxc = (r_y <= Y_LIM);
            n_sd3.lux  = '0;
        end else if (w_yq > U_MAX) begin
            n_sd3.luxc = 1'b1;
            n_sd3.lux  = 16'hFFFF;
        end else begin
            n_sd3.lux  = w_yq[15:0];
        end
    end

    always_comb begin
        n_sd4    = r_sd3;
        n_sd4.zs = (r_s == '0);
        n_sd5    = r_sd4;
        n_sd5.zd = (r_sb == r_yb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= PW'(K_XR) * PW'(w_r);
            r_p[1] <= PW'(K_XG) * PW'(w_g);
            r_p[2] <= PW'(K_XB) * PW'(w_b);
            r_p[3] <= PW'(K_YR) * PW'(w_r);
            r_p[4] <= PW'(K_YG) * PW'(w_g);
            r_p[5] <= PW'(K_YB) * PW'(w_b);
            r_p[6] <= PW'(K_ZR) * PW'(w_r);
            r_p[7] <= PW'(K_ZG) * PW'(w_g);
            r_p[8] <= PW'(K_ZB) * PW'(w_b);

            r_x <= XW'(r_p[0]) + XW'(r_p[1]) + XW'(r_p[2]);
            r_y <= XW'(r_p[3]) + XW'(r_p[4]) + XW'(r_p[5]);
            r_z <= XW'(r_p[6]) + XW'(r_p[7]) + XW'(r_p[8]);

            r_s   <= r_x + r_y + r_z;
            r_x3  <= r_x;
            r_y3  <= r_y;
            r_sd3 <= n_sd3;

            r_xa  <= NW'(r_x3) * M_10K;
            r_sa  <= NW'(r_s) * M_3320;
            r_sb  <= NW'(r_s) * M_1858;
            r_yb  <= NW'(r_y3) * M_10K;
            r_sd4 <= n_sd4;

            r_num <= r_xa - r_sa;
            r_den <= r_sb - r_yb;
            r_sd5 <= n_sd5;

            r_un  <= r_num[NW-1] ? MW'(-r_num) : MW'(r_num);
            r_ud  <= r_den[NW-1] ? MW'(-r_den) : MW'(r_den);
            r_neg <= r_num[NW-1] ^ r_den[NW-1];
            r_sd6 <= r_sd5;
        end
    end

    assign o_valid = r_v[5];
    assign o_un    = r_un;
    assign o_ud    = r_ud;
    assign o_neg   = r_neg;
    assign o_side  = r_sd6;

endmodule

// File: rtl/core/rct_div.sv
module rct_div
    import rct_pkg::*;
#(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [FRAC_BITS+32:0]        i_un,
    input  logic [FRAC_BITS+32:0]        i_ud,
    input  logic                         i_neg,
    input  t_side                        i_side,
    output logic                         o_valid,
    output logic signed [FRAC_BITS+7:0]  o_n,
    output t_side                        o_side
);

    localparam int MW = FRAC_BITS + 33;
    localparam int RW = MW + 7;
    localparam int QW = FRAC_BITS + 7;
    localparam int NQ = FRAC_BITS + 8;

    localparam logic signed [NQ-1:0] N_MAX = {1'b0, {(NQ-1){1'b1}}};
    localparam logic signed [NQ-1:0] N_MIN = {1'b1, {(NQ-1){1'b0}}};

    logic [QW+1:0]        r_v;
    logic [RW-1:0]        r_rem  [QW+1];
    logic [QW-1:0]        r_q    [QW+1];
    logic [MW-1:0]        r_d    [QW+1];
    logic                 r_neg  [QW+1];
    t_side                r_sd   [QW+1];
    logic signed [NQ-1:0] r_n;
    t_side                r_sdo;
    t_side                n_sd0;

    always_comb begin
        n_sd0     = i_side;
        n_sd0.sat = (RW'(i_un) >= {i_ud, 7'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_un);
            r_q[0]   <= '0;
            r_d[0]   <= i_ud;
            r_neg[0] <= i_neg;
            r_sd[0]  <= n_sd0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] w_dd, w_sub;
        logic          w_ge;

        assign w_dd  = {1'b0, r_d[k], 6'b0};
        assign w_ge  = (r_rem[k] >= w_dd);
        assign w_sub = w_ge ? (r_rem[k] - w_dd) : r_rem[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= {w_sub[RW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_sd[k+1]  <= r_sd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sd[QW].sat) begin
                r_n <= r_neg[QW] ? N_MIN : N_MAX;
            end else if (r_neg[QW]) begin
                r_n <= -$signed({1'b0, r_q[QW]});
            end else begin
                r_n <= $signed({1'b0, r_q[QW]});
            end
            r_sdo <= r_sd[QW];
        end
    end

    assign o_valid = r_v[QW+1];
    assign o_n     = r_n;
    assign o_side  = r_sdo;

endmodule

// File: rtl/core/rct_hmul.sv
module rct_hmul
    import rct_pkg::*;
#(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [FRAC_BITS+31:0]  i_acc,
    input  logic signed [FRAC_BITS+7:0]   i_n,
    input  logic signed [FRAC_BITS+31:0]  i_add,
    input  t_side                         i_side,
    output logic                          o_valid,
    output logic signed [FRAC_BITS+31:0]  o_acc,
    output logic signed [FRAC_BITS+7:0]   o_n,
    output t_side                         o_side
);

    localparam int AW = FRAC_BITS + 32;
    localparam int NQ = FRAC_BITS + 8;
    localparam int LW = FRAC_BITS + NQ;

    logic [3:0]           r_v;
    logic [AW-1:0]        r_ua;
    logic [NQ-1:0]        r_ub;
    logic                 r_ng1, r_ng2, r_ng3;
    logic [AW-1:0]        r_ph, r_pl, r_p;
    logic signed [AW-1:0] r_acc;
    logic signed [NQ-1:0] r_n1, r_n2, r_n3, r_n4;
    t_side                r_sd1, r_sd2, r_sd3, r_sd4;
    logic [LW-1:0]        w_pl;

    assign w_pl = LW'(r_ua[FRAC_BITS-1:0]) * LW'(r_ub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua  <= i_acc[AW-1] ? AW'(-i_acc) : AW'(i_acc);
            r_ub  <= i_n[NQ-1] ? NQ'(-i_n) : NQ'(i_n);
            r_ng1 <= i_acc[AW-1] ^ i_n[NQ-1];
            r_n1  <= i_n;
            r_sd1 <= i_side;

            r_ph  <= AW'(r_ua[AW-1:FRAC_BITS]) * AW'(r_ub);
            r_pl  <= AW'(w_pl[LW-1:FRAC_BITS]);
            r_ng2 <= r_ng1;
            r_n2  <= r_n1;
            r_sd2 <= r_sd1;

            r_p   <= r_ph + r_pl;
            r_ng3 <= r_ng2;
            r_n3  <= r_n2;
            r_sd3 <= r_sd2;

            r_acc <= (r_ng3 ? -$signed(r_p) : $signed(r_p)) + i_add;
            r_n4  <= r_n3;
            r_sd4 <= r_sd3;
        end
    end

    assign o_valid = r_v[3];
    assign o_acc   = r_acc;
    assign o_n     = r_n4;
    assign o_side  = r_sd4;

endmodule

// File: rtl/core/rct_cubic.sv
module rct_cubic
    import rct_pkg::*;
#(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [FRAC_BITS+7:0]  i_n,
    input  t_side                        i_side,
    output logic                         o_valid,
    output logic [15:0]                  o_kelvin,
    output logic [15:0]                  o_lux,
    output t_fault                       o_fault
);

    localparam int     AW = FRAC_BITS + 32;
    localparam int     NQ = FRAC_BITS + 8;
    localparam longint LF = 64'sd1 <<< FRAC_BITS;

    localparam logic signed [AW-1:0] C_449  = AW'(449);
    localparam logic signed [AW-1:0] C_3525 = AW'(3525 * LF);
    localparam logic signed [AW-1:0] C_6823 = AW'((68233 * LF + 5) / 10);
    localparam logic signed [AW-1:0] C_5520 = AW'((552033 * LF + 50) / 100);
    localparam logic signed [AW-1:0] K_LIM  = AW'(-LF);
    localparam logic signed [AW-1:0] U_MAX  = AW'(65535);

    logic                 r_v0, r_vo;
    logic signed [AW-1:0] r_acc0;
    logic signed [NQ-1:0] r_n0;
    t_side                r_sd0;
    logic [15:0]          r_kelvin, r_lux;
    t_fault               r_fault;

    logic                 w_v1, w_v2;
    logic signed [AW-1:0] w_acc1, w_acc2, w_q;
    logic signed [NQ-1:0] w_n1, w_n2;
    t_side                w_sd1, w_sd2;

    logic                 w_kc;
    logic [15:0]          w_k;
    t_fault               n_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_vo <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc0 <= AW'(i_n) * C_449 + C_3525;
            r_n0   <= i_n;
            r_sd0  <= i_side;
        end
    end

    rct_hmul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v0),
        .i_acc   (r_acc0),
        .i_n     (r_n0),
        .i_add   (C_6823),
        .i_side  (r_sd0),
        .o_valid (w_v1),
        .o_acc   (w_acc1),
        .o_n     (w_n1),
        .o_side  (w_sd1)
    );

    rct_hmul #(.FRAC_BITS(FRAC_BITS)) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (w_v1),
        .i_acc   (w_acc1),
        .i_n     (w_n1),
        .i_add   (C_5520),
        .i_side  (w_sd1),
        .o_valid (w_v2),
        .o_acc   (w_acc2),
        .o_n     (w_n2),
        .o_side  (w_sd2)
    );

    assign w_q = w_acc2 >>> FRAC_BITS;

    always_comb begin
        w_kc = 1'b0;
        w_k  = '0;
        if (w_acc2[AW-1]) begin
            w_kc = (w_acc2 <= K_LIM);
        end else if (w_q > U_MAX) begin
            w_kc = 1'b1;
            w_k  = 16'hFFFF;
        end else begin
            w_k  = w_q[15:0];
        end
    end

    always_comb begin
        if (w_sd2.zs) begin
            n_fault = FLT_SUM;
        end else if (w_sd2.zd) begin
            n_fault = FLT_DEN;
        end else if (w_sd2.sat || w_kc || w_sd2.luxc) begin
            n_fault = FLT_CLAMP;
        end else begin
            n_fault = FLT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kelvin <= (w_sd2.zs || w_sd2.zd) ? 16'd0 : w_k;
            r_lux    <= (w_sd2.zs || w_sd2.zd) ? 16'd0 : w_sd2.lux;
            r_fault  <= n_fault;
        end
    end

    assign o_valid  = r_vo;
    assign o_kelvin = r_kelvin;
    assign o_lux    = r_lux;
    assign o_fault  = r_fault;

endmodule

// File: rtl/core/rgb_to_color_temperature_unit.sv
// Colour temperature and illuminance from raw RGB sensor counts.
//
// Input stream s_axis: one word per sample, red, green and blue counts.
// Output stream m_axis: kelvin and lux in tdata, fault code in tuser
// (0 ok, 1 XYZ sum zero, 2 ratio denominator zero, 3 a value clamped).
//
// Throughput: one word per cycle, sustained unless the receiver stalls with a word waiting.
// Most pipeline stages are in the divider: FRAC_BITS + 7 stages resolve
// one quotient bit each, with a range check stage before them and a sign
// stage after; matrix and ratio set-up take 6 stages and the cubic 10.
//
// Reset clears every valid bit; words in flight are dropped and
// m_axis_tvalid falls in the cycle after reset.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and s_axis_tready falls; while the output register is empty the
// pipeline keeps advancing and accepting words.
module rgb_to_color_temperature_unit
    import rct_pkg::*;
#(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // kelvin, lux
    output logic [1:0]  m_axis_tuser    // fault
);

    localparam int MW = FRAC_BITS + 33;
    localparam int NQ = FRAC_BITS + 8;

    logic                 w_en;
    logic                 w_v1, w_v2, w_v3;
    logic [MW-1:0]        w_un, w_ud;
    logic                 w_neg;
    t_side                w_sd1, w_sd2;
    logic signed [NQ-1:0] w_n;
    logic [15:0]          w_kelvin, w_lux;
    t_fault               w_fault;

    assign w_en          = !w_v3 || m_axis_tready;
    assign s_axis_tready = w_en;

    rct_xyz #(.FRAC_BITS(FRAC_BITS)) u_xyz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_red   (s_axis_tdata[15:0]),
        .i_green (s_axis_tdata[31:16]),
        .i_blue  (s_axis_tdata[47:32]),
        .o_valid (w_v1),
        .o_un    (w_un),
        .o_ud    (w_ud),
        .o_neg   (w_neg),
        .o_side  (w_sd1)
    );

    rct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_un    (w_un),
        .i_ud    (w_ud),
        .i_neg   (w_neg),
        .i_side  (w_sd1),
        .o_valid (w_v2),
        .o_n     (w_n),
        .o_side  (w_sd2)
    );

    rct_cubic #(.FRAC_BITS(FRAC_BITS)) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_v2),
        .i_n      (w_n),
        .i_side   (w_sd2),
        .o_valid  (w_v3),
        .o_kelvin (w_kelvin),
        .o_lux    (w_lux),
        .o_fault  (w_fault)
    );

    assign m_axis_tvalid = w_v3;
    assign m_axis_tdata  = {w_lux, w_kelvin};
    assign m_axis_tuser  = w_fault;

endmodule

// File: rtl/core/rct_chk.sv
module rct_chk
    import rct_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == FLT_SUM || m_axis_tuser == FLT_DEN)
        |-> m_axis_tdata == 32'd0)
        else $error("fault word carries non-zero results");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind rgb_to_color_temperature_unit rct_chk u_rct_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb.sv
module tb;
    import rct_pkg::*;

    localparam int F = C_FRAC_BITS;

    typedef struct {
        logic [15:0] kelvin;
        logic [15:0] lux;
        t_fault      fault;
    } t_cct;

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint coef(longint num, longint den);
        longint unsigned q;
        q = ((mag(num) << F) + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fmul(longint a, longint b);
        longint unsigned ua, ub, msk, p;
        ua  = mag(a);
        ub  = mag(b);
        msk = (64'd1 << F) - 1;
        p   = (ua >> F) * ub + (((ua & msk) * ub) >> F);
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint ratio(longint num, longint den, inout bit sat);
        longint unsigned un, ud, q, r, fr;
        bit neg;
        un  = mag(num);
        ud  = mag(den);
        neg = (num < 0) != (den < 0);
        fr  = 0;
        if (un >= 128 * ud) begin
            sat = 1;
            return neg ? -(longint'(128) << F) : (longint'(128) << F) - 1;
        end
        q = un / ud;
        r = un % ud;
        for (int i = 0; i < F; i++) begin
            r  = r << 1;
            fr = fr << 1;
            if (r >= ud) begin
                r  = r - ud;
                fr = fr | 1;
            end
        end
        return neg ? -longint'((q << F) | fr) : longint'((q << F) | fr);
    endfunction

    function automatic logic [15:0] clamp16(longint v, inout bit flag);
        longint unsigned w;
        if (v < 0) begin
            if (v <= -(longint'(1) << F)) flag = 1;
            return 16'd0;
        end
        w = longint'(v) >> F;
        if (w > 65535) begin
            flag = 1;
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic t_cct cct_of(logic [15:0] rr, logic [15:0] gg, logic [15:0] bb);
        longint r, g, b, x, y, z, s, num, den, n, acc;
        bit flag;
        t_cct e;
        r = rr;
        g = gg;
        b = bb;
        flag = 0;
        x = coef(-14282, 100000) * r + coef(154924, 100000) * g + coef(-95641, 100000) * b;
        y = coef(-32466, 100000) * r + coef(157837, 100000) * g + coef(-73191, 100000) * b;
        z = coef(-68202, 100000) * r + coef(77073, 100000) * g + coef(56332, 100000) * b;
        s = x + y + z;
        e.kelvin = 0;
        e.lux    = 0;
        if (s == 0) begin
            e.fault = FLT_SUM;
            return e;
        end
        num = x * 10000 - s * 3320;
        den = s * 1858 - y * 10000;
        if (den == 0) begin
            e.fault = FLT_DEN;
            return e;
        end
        n   = ratio(num, den, flag);
        acc = longint'(449) << F;
        acc = fmul(acc, n) + (longint'(3525) << F);
        acc = fmul(acc, n) + coef(68233, 10);
        acc = fmul(acc, n) + coef(552033, 100);
        e.kelvin = clamp16(acc, flag);
        e.lux    = clamp16(y, flag);
        e.fault  = flag ? FLT_CLAMP : FLT_OK;
        return e;
    endfunction

    class cct_board;
        t_cct pending[$];
        int   errors = 0;

        function void note(logic [47:0] w);
            pending.push_back(cct_of(w[15:0], w[31:16], w[47:32]));
        endfunction

        function void check(logic [31:0] d, logic [1:0] u);
            t_cct e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h %h", d, u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.kelvin) begin
                $error("kelvin: expected %0d, got %0d", e.kelvin, d[15:0]);
                errors++;
            end
            if (d[31:16] !== e.lux) begin
                $error("lux: expected %0d, got %0d", e.lux, d[31:16]);
                errors++;
            end
            if (u !== e.fault) begin
                $error("fault: expected %0d, got %0d", e.fault, u);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;   // kelvin, lux
    logic [1:0]  m_axis_tuser;   // fault

    cct_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_cycles = 0;

    rgb_to_color_temperature_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_word(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note({b, g, r});
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random;
        logic [15:0] r, g, b, base;
        case ($urandom_range(3))
            0: begin
                r = 16'($urandom);
                g = 16'($urandom);
                b = 16'($urandom);
            end
            1: begin
                r = 16'($urandom_range(255));
                g = 16'($urandom_range(255));
                b = 16'($urandom_range(255));
            end
            default: begin
                base = 16'($urandom_range(60000, 16));
                r = base + 16'($urandom_range(base / 4));
                g = base + 16'($urandom_range(base / 4));
                b = base - 16'($urandom_range(base / 4));
            end
        endcase
        send_word(r, g, b);
    endtask

    initial begin
        t_cct e;
        bit got_den, got_sum;
        got_den = 0;
        got_sum = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_word(16'd0, 16'd0, 16'd0);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'hFFFF, 16'd0, 16'd0);
        send_word(16'd0, 16'hFFFF, 16'd0);
        send_word(16'd0, 16'd0, 16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF, 16'd0);
        send_word(16'd0, 16'hFFFF, 16'hFFFF);
        send_word(16'hFFFF, 16'd0, 16'hFFFF);
        send_word(16'd1, 16'd1, 16'd1);
        send_word(16'd1000, 16'd1000, 16'd1000);
        send_word(16'd3000, 16'd2000, 16'd1000);
        send_word(16'd1000, 16'd2000, 16'd3000);
        send_word(16'hAAAA, 16'h5555, 16'hAAAA);
        send_word(16'h5555, 16'hAAAA, 16'h5555);
        for (int r = 0; r < 48 && !(got_den && got_sum); r++)
            for (int g = 0; g < 48 && !(got_den && got_sum); g++)
                for (int b = 0; b < 48 && !(got_den && got_sum); b++) begin
                    if (r + g + b == 0) continue;
                    e = cct_of(16'(r), 16'(g), 16'(b));
                    if (e.fault == FLT_DEN && !got_den) begin
                        got_den = 1;
                        send_word(16'(r), 16'(g), 16'(b));
                    end
                    if (e.fault == FLT_SUM && !got_sum) begin
                        got_sum = 1;
                        send_word(16'(r), 16'(g), 16'(b));
                    end
                end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 66) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 66) : 0;
            for (int i = 0; i < 385; i++) begin
                if (ph == 0 && i == 100) hold_cycles = 300;
                if (ph == 1 && i == 200) drain();
                send_random();
            end
        end
        drain();
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: rgb_to_color_temperature_unit.f
rtl/core/rct_pkg.sv
rtl/core/rct_xyz.sv
rtl/core/rct_div.sv
rtl/core/rct_hmul.sv
rtl/core/rct_cubic.sv
rtl/core/rgb_to_color_temperature_unit.sv
rtl/core/rct_chk.sv
bench/tb.sv
